// ===== design/assert_macros.svh =====
// assertion macros shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication on clk, disabled in reset
`define CHK_IMPL(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("check failed");

// next-cycle implication on clk, disabled in reset
`define CHK_NEXT(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("check failed");

`endif

// ===== design/pcom_pkg.sv =====
// shared types and constants of the occupancy marker
`default_nettype none
package pcom_pkg;
    localparam logic [1:0] FUNC_CLEAR = 2'd0;
    localparam logic [1:0] FUNC_POINT = 2'd1;
    localparam logic [1:0] FUNC_WRITE = 2'd2;
    localparam logic [1:0] FUNC_READ  = 2'd3;

    localparam logic [2:0] REG_COS    = 3'd0;
    localparam logic [2:0] REG_SIN    = 3'd1;
    localparam logic [2:0] REG_OFFX   = 3'd2;
    localparam logic [2:0] REG_OFFY   = 3'd3;
    localparam logic [2:0] REG_CELL   = 3'd4;
    localparam logic [2:0] REG_WIDTH  = 3'd5;
    localparam logic [2:0] REG_HEIGHT = 3'd6;
    localparam logic [2:0] REG_STRIDE = 3'd7;

    localparam logic signed [15:0] DEPTH_MAX  = 16'sd5000;
    localparam logic signed [15:0] HEIGHT_LIM = 16'sd500;

    localparam int NCW = 14;

    typedef enum logic [2:0] {
        OP_CLEAR,
        OP_POINT,
        OP_DROP,
        OP_WRITE,
        OP_READ
    } op_t;

    typedef struct packed {
        op_t                op;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic [7:0]         col;
        logic [7:0]         row;
        logic               cbit;
    } item_t;

    typedef struct packed {
        logic signed [15:0] cos_q14;
        logic signed [15:0] sin_q14;
        logic signed [20:0] offset_x;
        logic signed [20:0] offset_y;
        logic [9:0]         cell_div;
        logic [8:0]         cols_lim;
        logic [8:0]         rows_lim;
        logic [4:0]         stride;
    } cfg_t;
endpackage
`default_nettype wire

// ===== design/pcom_front.sv =====
// front end: request acceptance, decimation and point filtering
`default_nettype none
module pcom_front
    import pcom_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [1:0]         func,
    input  wire logic signed [15:0] point_x,
    input  wire logic signed [15:0] point_y,
    input  wire logic signed [15:0] point_z,
    input  wire logic [7:0]         cell_col,
    input  wire logic [7:0]         cell_row,
    input  wire logic               cell_bit,
    input  wire logic [4:0]         stride,
    input  wire logic               queue_full,
    input  wire logic               init_busy,
    output logic                    busy,
    output logic                    push,
    output item_t                   entry
);
    logic [3:0] skip_reg;
    logic [3:0] skip_next;
    logic [4:0] skip_inc;
    logic       pass;

    assign busy     = queue_full | init_busy;
    assign push     = start & ~busy;
    assign skip_inc = {1'b0, skip_reg} + 5'd1;
    assign pass     = (skip_reg == 4'd0) && (point_z > 16'sd0) && (point_z <= DEPTH_MAX)
                      && (point_y >= -HEIGHT_LIM) && (point_y <= HEIGHT_LIM);

    always_comb
    begin
        skip_next   = skip_reg;
        entry.px    = point_x;
        entry.py    = point_y;
        entry.col   = cell_col;
        entry.row   = cell_row;
        entry.cbit  = cell_bit;
        entry.op    = OP_READ;
        unique case (func)
            FUNC_CLEAR:
            begin
                entry.op  = OP_CLEAR;
                skip_next = 4'd0;
            end
            FUNC_POINT:
            begin
                entry.op  = pass ? OP_POINT : OP_DROP;
                skip_next = (skip_inc >= stride) ? 4'd0 : skip_inc[3:0];
            end
            FUNC_WRITE: entry.op = OP_WRITE;
            default:    entry.op = OP_READ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            skip_reg <= 4'd0;
        else if (push)
            skip_reg <= skip_next;
    end
endmodule
`default_nettype wire

// ===== design/pcom_queue.sv =====
// two-entry request queue between front and back
`default_nettype none
module pcom_queue
    import pcom_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire item_t push_data,
    input  wire logic  pop,
    output item_t      pop_data,
    output logic       empty,
    output logic       full
);
    item_t      mem_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] count_reg;

    assign empty    = (count_reg == 2'd0);
    assign full     = (count_reg == 2'd2);
    assign pop_data = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wptr_reg <= ~wptr_reg;
            if (pop)
                rptr_reg <= ~rptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end
endmodule
`default_nettype wire

// ===== design/pcom_back.sv =====
// back end: projection, cell division, grid stores and neighborhood read
`default_nettype none
module pcom_back
    import pcom_pkg::*;
#(
    parameter int MAX_COLS       = 256,
    parameter int MAX_ROWS       = 256,
    parameter int INFLATE_RADIUS = 2
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire item_t item,
    input  wire logic  queue_empty,
    output logic       pop,
    output logic       init_busy,
    output logic       done,
    output logic       in_grid,
    output logic       marked,
    output logic [7:0] hit_col,
    output logic [7:0] hit_row,
    output logic       occupied
);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int AW    = CW + RW;
    localparam int DEPTH = 1 << AW;
    localparam logic signed [2:0] RAD = 3'(INFLATE_RADIUS);

    typedef enum logic [13:0] {
        S_INIT = 14'b00000000000001,
        S_IDLE = 14'b00000000000010,
        S_MUL1 = 14'b00000000000100,
        S_MUL2 = 14'b00000000001000,
        S_SUM  = 14'b00000000010000,
        S_DIV  = 14'b00000000100000,
        S_CHK  = 14'b00000001000000,
        S_MARK = 14'b00000010000000,
        S_CLR  = 14'b00000100000000,
        S_WR   = 14'b00001000000000,
        S_RDS  = 14'b00010000000000,
        S_RDN  = 14'b00100000000000,
        S_RDF  = 14'b01000000000000,
        S_DROP = 14'b10000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic static_mem  [DEPTH];
    logic dynamic_mem [DEPTH];
    logic st_rdata_reg;
    logic dy_rdata_reg;

    logic          st_we, st_wdata, st_re;
    logic [AW-1:0] st_waddr, st_raddr;
    logic          dy_we, dy_wdata, dy_re;
    logic [AW-1:0] dy_waddr, dy_raddr;

    item_t              item_reg;
    logic [AW-1:0]      clr_reg;
    logic signed [31:0] prod_a_reg, prod_b_reg, prod_c_reg, prod_d_reg;
    logic [21:0]        dvx_reg, dvy_reg;
    logic [9:0]         remx_reg, remy_reg;
    logic               negx_reg, negy_reg;
    logic [4:0]         div_cnt_reg;
    logic               inside_reg;
    logic [AW-1:0]      addr_reg;
    logic signed [2:0]  dr_reg, dc_reg;
    logic               nbv_reg, stv_reg, occ_reg;

    logic               done_reg, in_grid_reg, marked_reg, occupied_reg;
    logic [7:0]         hit_col_reg, hit_row_reg;

    logic signed [32:0] sum_x, sum_y;
    logic signed [21:0] wx, wy;
    logic [10:0]        remx_sh, remy_sh;
    logic               qbx, qby;
    logic               inside_pt;
    logic signed [NCW-1:0] base_c, base_r, nb_c, nb_r;
    logic               inside_base, nb_corner, nb_valid, nb_last, occ_fold;

    function automatic logic in_bounds(input logic signed [NCW-1:0] c,
                                       input logic signed [NCW-1:0] r,
                                       input logic [8:0] cl, input logic [8:0] rl);
        logic signed [NCW-1:0] cls, rls;
        begin
            cls = $signed(NCW'(cl));
            rls = $signed(NCW'(rl));
            return (c >= 0) && (r >= 0) && (c < cls) && (r < rls);
        end
    endfunction

    function automatic logic [AW-1:0] cell_addr(input logic [NCW-1:0] c,
                                                input logic [NCW-1:0] r);
        return {r[RW-1:0], c[CW-1:0]};
    endfunction

    assign sum_x   = 33'(prod_a_reg) - 33'(prod_b_reg);
    assign sum_y   = 33'(prod_c_reg) + 33'(prod_d_reg);
    assign wx      = 22'(sum_x >>> 14) + 22'(cfg.offset_x);
    assign wy      = 22'(sum_y >>> 14) + 22'(cfg.offset_y);
    assign remx_sh = {remx_reg, dvx_reg[21]};
    assign remy_sh = {remy_reg, dvy_reg[21]};
    assign qbx     = remx_sh >= {1'b0, cfg.cell_div};
    assign qby     = remy_sh >= {1'b0, cfg.cell_div};

    assign inside_pt = (!negx_reg || dvx_reg == 22'd0) && (!negy_reg || dvy_reg == 22'd0)
                       && (dvx_reg < 22'(cfg.cols_lim)) && (dvy_reg < 22'(cfg.rows_lim));

    assign base_c      = $signed(NCW'(item_reg.col));
    assign base_r      = $signed(NCW'(item_reg.row));
    assign nb_c        = base_c + NCW'(dc_reg);
    assign nb_r        = base_r + NCW'(dr_reg);
    assign inside_base = in_bounds(base_c, base_r, cfg.cols_lim, cfg.rows_lim);
    assign nb_corner   = (dr_reg == RAD || dr_reg == -RAD) && (dc_reg == RAD || dc_reg == -RAD);
    assign nb_valid    = !nb_corner && in_bounds(nb_c, nb_r, cfg.cols_lim, cfg.rows_lim);
    assign nb_last     = (dr_reg == RAD) && (dc_reg == RAD);
    assign occ_fold    = occ_reg | (nbv_reg & dy_rdata_reg) | (stv_reg & st_rdata_reg);

    assign pop       = (state_reg == S_IDLE) && !queue_empty;
    assign init_busy = (state_reg == S_INIT);

    always_comb
    begin
        state_next = state_reg;
        st_we    = 1'b0;
        st_wdata = 1'b0;
        st_waddr = clr_reg;
        st_re    = 1'b0;
        st_raddr = addr_reg;
        dy_we    = 1'b0;
        dy_wdata = 1'b0;
        dy_waddr = clr_reg;
        dy_re    = 1'b0;
        dy_raddr = cell_addr(nb_c, nb_r);
        unique case (state_reg)
            S_INIT:
            begin
                st_we = 1'b1;
                dy_we = 1'b1;
                if (clr_reg == {AW{1'b1}})
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (!queue_empty)
                begin
                    case (item.op)
                        OP_CLEAR: state_next = S_CLR;
                        OP_POINT: state_next = S_MUL1;
                        OP_WRITE: state_next = S_WR;
                        OP_READ:  state_next = S_RDS;
                        default:  state_next = S_DROP;
                    endcase
                end
            end
            S_MUL1: state_next = S_MUL2;
            S_MUL2: state_next = S_SUM;
            S_SUM:  state_next = S_DIV;
            S_DIV:
            begin
                if (div_cnt_reg == 5'd0)
                    state_next = S_CHK;
            end
            S_CHK:
            begin
                st_re      = 1'b1;
                st_raddr   = cell_addr(dvx_reg[NCW-1:0], dvy_reg[NCW-1:0]);
                state_next = S_MARK;
            end
            S_MARK:
            begin
                dy_we      = inside_reg && !st_rdata_reg;
                dy_wdata   = 1'b1;
                dy_waddr   = addr_reg;
                state_next = S_IDLE;
            end
            S_CLR:
            begin
                dy_we = 1'b1;
                if (clr_reg == {AW{1'b1}})
                    state_next = S_IDLE;
            end
            S_WR:
            begin
                st_we      = inside_base;
                st_wdata   = item_reg.cbit;
                st_waddr   = cell_addr(base_c, base_r);
                state_next = S_IDLE;
            end
            S_RDS:
            begin
                st_re      = 1'b1;
                st_raddr   = cell_addr(base_c, base_r);
                state_next = S_RDN;
            end
            S_RDN:
            begin
                dy_re = nb_valid;
                if (nb_last)
                    state_next = S_RDF;
            end
            S_RDF:  state_next = S_IDLE;
            S_DROP: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
            static_mem[st_waddr] <= st_wdata;
        if (st_re)
            st_rdata_reg <= static_mem[st_raddr];
        if (dy_we)
            dynamic_mem[dy_waddr] <= dy_wdata;
        if (dy_re)
            dy_rdata_reg <= dynamic_mem[dy_raddr];
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                item_reg <= item;
            end
            S_MUL1:
            begin
                prod_a_reg <= cfg.cos_q14 * item_reg.px;
                prod_b_reg <= cfg.sin_q14 * item_reg.py;
            end
            S_MUL2:
            begin
                prod_c_reg <= cfg.sin_q14 * item_reg.px;
                prod_d_reg <= cfg.cos_q14 * item_reg.py;
            end
            S_SUM:
            begin
                negx_reg    <= wx[21];
                negy_reg    <= wy[21];
                dvx_reg     <= wx[21] ? 22'(-wx) : 22'(wx);
                dvy_reg     <= wy[21] ? 22'(-wy) : 22'(wy);
                remx_reg    <= 10'd0;
                remy_reg    <= 10'd0;
                div_cnt_reg <= 5'd21;
            end
            S_DIV:
            begin
                remx_reg    <= qbx ? 10'(remx_sh - {1'b0, cfg.cell_div}) : remx_sh[9:0];
                remy_reg    <= qby ? 10'(remy_sh - {1'b0, cfg.cell_div}) : remy_sh[9:0];
                dvx_reg     <= {dvx_reg[20:0], qbx};
                dvy_reg     <= {dvy_reg[20:0], qby};
                div_cnt_reg <= div_cnt_reg - 5'd1;
            end
            S_CHK:
            begin
                inside_reg <= inside_pt;
                addr_reg   <= cell_addr(dvx_reg[NCW-1:0], dvy_reg[NCW-1:0]);
            end
            S_RDS:
            begin
                stv_reg <= inside_base;
                nbv_reg <= 1'b0;
                occ_reg <= 1'b0;
                dr_reg  <= -RAD;
                dc_reg  <= -RAD;
            end
            S_RDN:
            begin
                occ_reg <= occ_fold;
                nbv_reg <= nb_valid;
                if (dc_reg == RAD)
                begin
                    dc_reg <= -RAD;
                    dr_reg <= dr_reg + 3'sd1;
                end
                else
                begin
                    dc_reg <= dc_reg + 3'sd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_INIT;
            clr_reg      <= '0;
            done_reg     <= 1'b0;
            in_grid_reg  <= 1'b0;
            marked_reg   <= 1'b0;
            hit_col_reg  <= 8'd0;
            hit_row_reg  <= 8'd0;
            occupied_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            done_reg     <= 1'b0;
            in_grid_reg  <= 1'b0;
            marked_reg   <= 1'b0;
            hit_col_reg  <= 8'd0;
            hit_row_reg  <= 8'd0;
            occupied_reg <= 1'b0;
            if (state_reg == S_INIT || state_reg == S_CLR)
                clr_reg <= clr_reg + 1'b1;
            case (state_reg)
                S_MARK:
                begin
                    done_reg    <= 1'b1;
                    in_grid_reg <= inside_reg;
                    marked_reg  <= inside_reg && !st_rdata_reg;
                    if (inside_reg)
                    begin
                        hit_col_reg <= dvx_reg[7:0];
                        hit_row_reg <= dvy_reg[7:0];
                    end
                end
                S_RDF:
                begin
                    done_reg     <= 1'b1;
                    occupied_reg <= stv_reg & occ_fold;
                end
                S_WR, S_DROP:
                begin
                    done_reg <= 1'b1;
                end
                S_CLR:
                begin
                    if (clr_reg == {AW{1'b1}})
                        done_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign done     = done_reg;
    assign in_grid  = in_grid_reg;
    assign marked   = marked_reg;
    assign hit_col  = hit_col_reg;
    assign hit_row  = hit_row_reg;
    assign occupied = occupied_reg;
endmodule
`default_nettype wire

// ===== design/point_cloud_occupancy_marker.sv =====
// top level: configuration registers, front end, queue and back end
// point request, accept to result: 2 multiply steps, 22-step divider, map access
// read request: walks the (2*INFLATE_RADIUS+1) squared window, one position per cycle
// clear request: one dynamic map entry per cycle; write request: one static map write
// after reset busy stays high while both maps are swept clear
// back end runs one request at a time; a two-entry queue takes requests while it works
`default_nettype none
module point_cloud_occupancy_marker
    import pcom_pkg::*;
#(
    parameter int MAX_COLS       = 256,
    parameter int MAX_ROWS       = 256,
    parameter int INFLATE_RADIUS = 2
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         func,
    input  wire logic signed [15:0] point_x,
    input  wire logic signed [15:0] point_y,
    input  wire logic signed [15:0] point_z,
    input  wire logic [7:0]         cell_col,
    input  wire logic [7:0]         cell_row,
    input  wire logic               cell_bit,
    input  wire logic               wr_en,
    input  wire logic [2:0]         wr_index,
    input  wire logic [20:0]        wr_data,
    output logic                    done,
    output logic                    in_grid,
    output logic                    marked,
    output logic [7:0]              hit_col,
    output logic [7:0]              hit_row,
    output logic                    occupied
);
    logic signed [15:0] cos_reg, sin_reg;
    logic signed [20:0] offx_reg, offy_reg;
    logic [9:0]         cell_reg;
    logic [8:0]         width_reg, height_reg;
    logic [4:0]         stride_reg;
    cfg_t               cfg;

    logic  queue_full, queue_empty, init_busy, push, pop;
    item_t entry, head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_reg    <= 16'sd16384;
            sin_reg    <= 16'sd0;
            offx_reg   <= 21'sd0;
            offy_reg   <= 21'sd0;
            cell_reg   <= 10'd50;
            width_reg  <= 9'd256;
            height_reg <= 9'd256;
            stride_reg <= 5'd10;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_COS:    cos_reg    <= wr_data[15:0];
                REG_SIN:    sin_reg    <= wr_data[15:0];
                REG_OFFX:   offx_reg   <= wr_data;
                REG_OFFY:   offy_reg   <= wr_data;
                REG_CELL:   cell_reg   <= wr_data[9:0];
                REG_WIDTH:  width_reg  <= wr_data[8:0];
                REG_HEIGHT: height_reg <= wr_data[8:0];
                REG_STRIDE: stride_reg <= wr_data[4:0];
                default:    cell_reg   <= cell_reg;
            endcase
        end
    end

    always_comb
    begin
        cfg.cos_q14  = cos_reg;
        cfg.sin_q14  = sin_reg;
        cfg.offset_x = offx_reg;
        cfg.offset_y = offy_reg;
        cfg.cell_div = (cell_reg == 10'd0) ? 10'd1 : cell_reg;
        cfg.cols_lim = (32'(width_reg) > MAX_COLS) ? 9'(MAX_COLS) : width_reg;
        cfg.rows_lim = (32'(height_reg) > MAX_ROWS) ? 9'(MAX_ROWS) : height_reg;
        if (stride_reg == 5'd0)
            cfg.stride = 5'd1;
        else if (stride_reg > 5'd16)
            cfg.stride = 5'd16;
        else
            cfg.stride = stride_reg;
    end

    pcom_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .func       (func),
        .point_x    (point_x),
        .point_y    (point_y),
        .point_z    (point_z),
        .cell_col   (cell_col),
        .cell_row   (cell_row),
        .cell_bit   (cell_bit),
        .stride     (cfg.stride),
        .queue_full (queue_full),
        .init_busy  (init_busy),
        .busy       (busy),
        .push       (push),
        .entry      (entry)
    );

    pcom_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (entry),
        .pop       (pop),
        .pop_data  (head),
        .empty     (queue_empty),
        .full      (queue_full)
    );

    pcom_back #(
        .MAX_COLS       (MAX_COLS),
        .MAX_ROWS       (MAX_ROWS),
        .INFLATE_RADIUS (INFLATE_RADIUS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .item        (head),
        .queue_empty (queue_empty),
        .pop         (pop),
        .init_busy   (init_busy),
        .done        (done),
        .in_grid     (in_grid),
        .marked      (marked),
        .hit_col     (hit_col),
        .hit_row     (hit_row),
        .occupied    (occupied)
    );
endmodule
`default_nettype wire

// ===== design/pcom_checker.sv =====
// port-level checks on the result stream, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module pcom_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       done,
    input wire logic       in_grid,
    input wire logic       marked,
    input wire logic [7:0] hit_col,
    input wire logic [7:0] hit_row,
    input wire logic       occupied
);
    `CHK_NEXT(a_done_gap, done, !done)
    `CHK_IMPL(a_mark_in_grid, done && marked, in_grid)
    `CHK_IMPL(a_miss_no_cell, done && !in_grid, hit_col == 8'd0 && hit_row == 8'd0)
    `CHK_IMPL(a_point_no_occ, done && in_grid, !occupied)
    `CHK_IMPL(a_idle_quiet, !done, !in_grid && !marked && !occupied)
endmodule

bind point_cloud_occupancy_marker pcom_checker u_chk (.*);
`default_nettype wire

// ===== bench/tb_top.sv =====
// testbench for the point cloud occupancy marker: directed table, then random requests
`default_nettype none
module tb_top;
    import pcom_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID_COLS = 256;
    localparam int GRID_ROWS = 256;
    localparam int RADIUS = 2;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE_CYCLES = 64;

    typedef struct packed {
        logic       in_grid;
        logic       marked;
        logic [7:0] hit_col;
        logic [7:0] hit_row;
        logic       occupied;
    } hit_t;

    typedef struct packed {
        logic [1:0]  fn;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        logic [7:0]  col;
        logic [7:0]  row;
        logic        cbit;
        logic        typed;
        hit_t        want;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [1:0] func;
    logic signed [15:0] point_x, point_y, point_z;
    logic [7:0] cell_col, cell_row;
    logic cell_bit;
    logic wr_en;
    logic [2:0] wr_index;
    logic [20:0] wr_data;
    logic done, in_grid, marked, occupied;
    logic [7:0] hit_col, hit_row;

    hit_t expected_hits[$];
    int errors = 0;
    longint cycles = 0;
    int idle_pct = 0;

    cfg_t shadow_cfg;
    bit static_cells[GRID_ROWS*GRID_COLS];
    bit dynamic_cells[GRID_ROWS*GRID_COLS];
    logic [3:0] skip_cnt;
    int last_col = 0, last_row = 0;

    point_cloud_occupancy_marker dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .func(func),
        .point_x(point_x), .point_y(point_y), .point_z(point_z),
        .cell_col(cell_col), .cell_row(cell_row), .cell_bit(cell_bit),
        .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
        .done(done), .in_grid(in_grid), .marked(marked),
        .hit_col(hit_col), .hit_row(hit_row), .occupied(occupied)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("tb_top failed");
                $finish;
            end
        end
    end

    function automatic bit in_bounds(longint c, longint r);
        longint nc, nr;
        nc = shadow_cfg.cols_lim > GRID_COLS ? GRID_COLS : longint'(shadow_cfg.cols_lim);
        nr = shadow_cfg.rows_lim > GRID_ROWS ? GRID_ROWS : longint'(shadow_cfg.rows_lim);
        return c >= 0 && r >= 0 && c < nc && r < nr;
    endfunction

    function automatic void shadow_write(logic [2:0] idx, logic [20:0] val);
        case (idx)
            REG_COS:    shadow_cfg.cos_q14 = val[15:0];
            REG_SIN:    shadow_cfg.sin_q14 = val[15:0];
            REG_OFFX:   shadow_cfg.offset_x = val;
            REG_OFFY:   shadow_cfg.offset_y = val;
            REG_CELL:   shadow_cfg.cell_div = val[9:0];
            REG_WIDTH:  shadow_cfg.cols_lim = val[8:0];
            REG_HEIGHT: shadow_cfg.rows_lim = val[8:0];
            default:    shadow_cfg.stride = val[4:0];
        endcase
    endfunction

    function automatic hit_t predict_occupancy(stim_row_t s);
        hit_t h;
        longint px, py, pz, wx, wy, gx, gy, dv, c, r;
        int stride_n;
        bit take;
        h = '0;
        px = $signed(s.x);
        py = $signed(s.y);
        pz = $signed(s.z);
        c = longint'(s.col);
        r = longint'(s.row);
        case (s.fn)
            FUNC_CLEAR:
            begin
                foreach (dynamic_cells[i]) dynamic_cells[i] = 1'b0;
                skip_cnt = '0;
            end
            FUNC_POINT:
            begin
                stride_n = shadow_cfg.stride == 0 ? 1 :
                           (shadow_cfg.stride > 16 ? 16 : int'(shadow_cfg.stride));
                take = skip_cnt == 0;
                skip_cnt = (skip_cnt + 1 >= stride_n) ? 4'd0 : skip_cnt + 4'd1;
                if (take && pz > 0 && pz <= DEPTH_MAX && py >= -HEIGHT_LIM && py <= HEIGHT_LIM)
                begin
                    dv = shadow_cfg.cell_div == 0 ? 1 : longint'(shadow_cfg.cell_div);
                    wx = ((shadow_cfg.cos_q14 * px - shadow_cfg.sin_q14 * py) >>> 14)
                         + shadow_cfg.offset_x;
                    wy = ((shadow_cfg.sin_q14 * px + shadow_cfg.cos_q14 * py) >>> 14)
                         + shadow_cfg.offset_y;
                    gx = wx / dv;
                    gy = wy / dv;
                    if (in_bounds(gx, gy))
                    begin
                        h.in_grid = 1'b1;
                        h.hit_col = gx[7:0];
                        h.hit_row = gy[7:0];
                        last_col = int'(gx);
                        last_row = int'(gy);
                        if (!static_cells[gy*GRID_COLS+gx])
                        begin
                            dynamic_cells[gy*GRID_COLS+gx] = 1'b1;
                            h.marked = 1'b1;
                        end
                    end
                end
            end
            FUNC_WRITE:
            begin
                if (in_bounds(c, r))
                    static_cells[r*GRID_COLS+c] = s.cbit;
            end
            default:
            begin
                if (in_bounds(c, r))
                begin
                    h.occupied = static_cells[r*GRID_COLS+c];
                    for (longint dr = -RADIUS; dr <= RADIUS; dr++)
                        for (longint dc = -RADIUS; dc <= RADIUS; dc++)
                            if (!((dr == RADIUS || dr == -RADIUS) &&
                                  (dc == RADIUS || dc == -RADIUS)) &&
                                in_bounds(c + dc, r + dr))
                                h.occupied |= dynamic_cells[(r+dr)*GRID_COLS+c+dc];
                end
            end
        endcase
        return h;
    endfunction

    function automatic stim_row_t mk(logic [1:0] fn, int x, int y, int z, int col, int row,
                                     bit cb, bit typed, hit_t want);
        stim_row_t s;
        s.fn = fn; s.x = 16'(x); s.y = 16'(y); s.z = 16'(z); s.col = 8'(col); s.row = 8'(row);
        s.cbit = cb; s.typed = typed; s.want = want;
        return s;
    endfunction

    task automatic send_request(stim_row_t s);
        hit_t h;
        int gap;
        start <= 1'b1;
        func <= s.fn;
        point_x <= s.x;
        point_y <= s.y;
        point_z <= s.z;
        cell_col <= s.col;
        cell_row <= s.row;
        cell_bit <= s.cbit;
        do @(negedge clk); while (busy);
        h = predict_occupancy(s);
        expected_hits = {expected_hits, (s.typed ? s.want : h)};
        @(posedge clk);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            gap = int'($urandom_range(1, 6));
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_reg(logic [2:0] idx, logic [20:0] val);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        shadow_write(idx, val);
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    task automatic drain;
        start <= 1'b0;
        @(posedge clk);
        wait (expected_hits.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_all(int cs, int sn, int ox, int oy, int cm, int w, int ht, int st);
        write_reg(REG_COS, 21'(cs));
        write_reg(REG_SIN, 21'(sn));
        write_reg(REG_OFFX, 21'(ox));
        write_reg(REG_OFFY, 21'(oy));
        write_reg(REG_CELL, 21'(cm));
        write_reg(REG_WIDTH, 21'(w));
        write_reg(REG_HEIGHT, 21'(ht));
        write_reg(REG_STRIDE, 21'(st));
    endtask

    function automatic stim_row_t random_row();
        stim_row_t s;
        int pick;
        s = '0;
        pick = int'($urandom_range(99));
        s.cbit = 1'($urandom_range(1));
        if (pick < 60)
        begin
            s.fn = FUNC_POINT;
            if ($urandom_range(9) < 8)
            begin
                s.x = 16'(int'($urandom_range(10000)) - 5000);
                s.y = 16'(int'($urandom_range(1000)) - 500);
                s.z = 16'($urandom_range(1, 5000));
            end
            else
            begin
                s.x = 16'($urandom);
                s.y = 16'($urandom);
                s.z = 16'($urandom);
            end
        end
        else
        begin
            s.fn = pick < 75 ? FUNC_WRITE : FUNC_READ;
            s.x = 16'($urandom);
            s.y = 16'($urandom);
            s.z = 16'($urandom);
            if ($urandom_range(3) == 0)
            begin
                s.col = 8'($urandom);
                s.row = 8'($urandom);
            end
            else
            begin
                s.col = 8'(last_col + int'($urandom_range(6)) - 3);
                s.row = 8'(last_row + int'($urandom_range(6)) - 3);
            end
        end
        return s;
    endfunction

    always @(negedge clk)
    begin
        hit_t got, want;
        if (rst_n && done)
        begin
            got = '{in_grid, marked, hit_col, hit_row, occupied};
            if (expected_hits.size() == 0)
            begin
                $error("result with no request outstanding");
                errors++;
            end
            else
            begin
                want = expected_hits.pop_front();
                if (got.in_grid !== want.in_grid)
                begin
                    $error("in_grid expected %0d got %0d", want.in_grid, got.in_grid);
                    errors++;
                end
                if (got.marked !== want.marked)
                begin
                    $error("marked expected %0d got %0d", want.marked, got.marked);
                    errors++;
                end
                if (got.hit_col !== want.hit_col)
                begin
                    $error("hit_col expected %0d got %0d", want.hit_col, got.hit_col);
                    errors++;
                end
                if (got.hit_row !== want.hit_row)
                begin
                    $error("hit_row expected %0d got %0d", want.hit_row, got.hit_row);
                    errors++;
                end
                if (got.occupied !== want.occupied)
                begin
                    $error("occupied expected %0d got %0d", want.occupied, got.occupied);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        stim_row_t rows[$];
        hit_t z0;
        int phase_idle[6];
        int clear_at;
        stim_row_t s;
        phase_idle = '{0, 71, 0, 21, 71, 0};
        z0 = '0;
        start = 1'b0;
        func = FUNC_CLEAR;
        point_x = '0;
        point_y = '0;
        point_z = '0;
        cell_col = '0;
        cell_row = '0;
        cell_bit = 1'b0;
        wr_en = 1'b0;
        wr_index = REG_COS;
        wr_data = '0;
        rst_n = 1'b0;
        shadow_cfg = '{16'sd16384, 16'sd0, 21'sd0, 21'sd0, 10'd50, 9'd256, 9'd256, 5'd10};
        skip_cnt = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(REG_STRIDE, 21'd1);
        rows = {rows, mk(FUNC_READ, 0, 0, 0, 0, 0, 0, 1, z0)};
        rows = {rows, mk(FUNC_READ, -1, -1, -1, 255, 255, 1, 1, z0)};
        rows = {rows, mk(FUNC_POINT, 100, 0, 0, 0, 0, 0, 1, z0)};
        rows = {rows, mk(FUNC_POINT, 100, 0, 5001, 0, 0, 0, 1, z0)};
        rows = {rows, mk(FUNC_POINT, 100, 501, 100, 0, 0, 0, 1, z0)};
        rows = {rows, mk(FUNC_POINT, 100, -501, 100, 0, 0, 0, 1, z0)};
        rows = {rows, mk(FUNC_POINT, -32768, 0, 1, 0, 0, 0, 1, z0)};
        rows = {rows, mk(FUNC_POINT, 0, 0, 100, 0, 0, 0, 1, '{1, 1, 0, 0, 0})};
        rows = {rows, mk(FUNC_POINT, 1000, 500, 5000, 0, 0, 0, 1, '{1, 1, 20, 10, 0})};
        rows = {rows, mk(FUNC_WRITE, 0, 0, 0, 20, 10, 1, 1, z0)};
        rows = {rows, mk(FUNC_POINT, 1000, 500, 5000, 0, 0, 0, 1, '{1, 0, 20, 10, 0})};
        rows = {rows, mk(FUNC_READ, 0, 0, 0, 20, 10, 0, 1, '{0, 0, 0, 0, 1})};
        rows = {rows, mk(FUNC_READ, 0, 0, 0, 22, 10, 0, 0, z0)};
        rows = {rows, mk(FUNC_READ, 0, 0, 0, 22, 12, 0, 0, z0)};
        rows = {rows, mk(FUNC_READ, 0, 0, 0, 2, 2, 0, 0, z0)};
        rows = {rows, mk(FUNC_POINT, 32767, -500, 1, 0, 0, 0, 0, z0)};
        rows = {rows, mk(FUNC_WRITE, 0, 0, 0, 20, 10, 0, 0, z0)};
        rows = {rows, mk(FUNC_CLEAR, -1, -1, -1, 255, 255, 1, 1, z0)};
        rows = {rows, mk(FUNC_READ, 0, 0, 0, 20, 10, 0, 1, z0)};
        foreach (rows[i]) send_request(rows[i]);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            idle_pct = phase_idle[ph];
            case (ph)
                0: write_all(16384, 0, 0, 0, 50, 256, 256, 10);
                1: write_all(-16384, 16384, -1048576, 1048575, 1, 1, 1, 16);
                2: write_all(16384, 0, 0, 0, 1000, 256, 256, 1);
                3: write_all(0, -16384, 6000, 6000, 0, 511, 0, 0);
                default: write_all(int'($urandom_range(32768)) - 16384,
                                   int'($urandom_range(32768)) - 16384,
                                   int'($urandom_range(8000)), int'($urandom_range(8000)),
                                   int'($urandom_range(5, 80)), int'($urandom_range(1, 300)),
                                   int'($urandom_range(1, 300)), int'($urandom_range(31) % 4));
            endcase
            clear_at = int'($urandom_range(20, 230));
            for (int n = 0; n < 250; n++)
            begin
                s = random_row();
                if (n == clear_at)
                    s.fn = FUNC_CLEAR;
                send_request(s);
            end
            drain();
        end

        if (errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule
`default_nettype wire
